### hdl/lcdenc_pkg.sv
package lcdenc_pkg;

    // One controller instruction: {RS, RW, D7..D0}
    typedef logic [9:0] t_instr;

    localparam int MAX_INS   = 4;
    localparam int QUEUE_DEP = 2;

    typedef struct packed {
        logic [2:0]                count;   // 0..MAX_INS instructions
        logic [MAX_INS-1:0][9:0]   instr;   // sent in order from index 0
    } t_job;

    // Input function codes
    localparam logic [2:0] FN_BEGIN_HALF = 3'd0;
    localparam logic [2:0] FN_HALF_CHAR  = 3'd1;
    localparam logic [2:0] FN_END_HALF   = 3'd2;
    localparam logic [2:0] FN_BEGIN_FULL = 3'd3;
    localparam logic [2:0] FN_FULL_CHAR  = 3'd4;
    localparam logic [2:0] FN_DISP_FLAG  = 3'd5;
    localparam logic [2:0] FN_COMMAND    = 3'd6;

    // Display flag options
    localparam logic [1:0] OPT_DISPLAY   = 2'd0;
    localparam logic [1:0] OPT_UNDERLINE = 2'd1;
    localparam logic [1:0] OPT_BLINK     = 2'd2;

    // Commands
    localparam logic [3:0] CMD_CLEAR      = 4'd0;
    localparam logic [3:0] CMD_HOME       = 4'd1;
    localparam logic [3:0] CMD_CUR_LEFT   = 4'd2;
    localparam logic [3:0] CMD_CUR_RIGHT  = 4'd3;
    localparam logic [3:0] CMD_SHIFT_LEFT = 4'd4;
    localparam logic [3:0] CMD_SHIFT_RGHT = 4'd5;
    localparam logic [3:0] CMD_ENTRY_CR   = 4'd6;
    localparam logic [3:0] CMD_ENTRY_CL   = 4'd7;
    localparam logic [3:0] CMD_ENTRY_DSR  = 4'd8;
    localparam logic [3:0] CMD_ENTRY_DSL  = 4'd9;
    localparam logic [3:0] CMD_INIT       = 4'd10;

    // Byte phases within one instruction frame
    localparam logic [1:0] PH_SYNC = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    // Instruction words
    localparam t_instr INS_SET_ADDR   = 10'h080;
    localparam t_instr INS_DATA       = 10'h200;
    localparam t_instr INS_SPACE      = 10'h220;
    localparam t_instr INS_DISP_CTRL  = 10'h008;
    localparam t_instr INS_FUNC_BASIC = 10'h030;
    localparam t_instr INS_CLEAR      = 10'h001;
    localparam t_instr INS_ENTRY_CR   = 10'h006;
    localparam t_instr INS_HOME       = 10'h002;
    localparam t_instr INS_CUR_LEFT   = 10'h010;
    localparam t_instr INS_CUR_RIGHT  = 10'h014;
    localparam t_instr INS_SHIFT_LEFT = 10'h018;
    localparam t_instr INS_SHIFT_RGHT = 10'h01C;
    localparam t_instr INS_ENTRY_CL   = 10'h004;
    localparam t_instr INS_ENTRY_DSR  = 10'h005;
    localparam t_instr INS_ENTRY_DSL  = 10'h007;

    localparam logic [7:0] SYNC_BASE = 8'hF8;

    // Set-address for a cell 0..31 with the panel's folded row layout
    function automatic t_instr set_addr(input logic [4:0] slot);
        logic [4:0] a;
        case (slot[4:3])
            2'b01:   a = slot + 5'd8;
            2'b10:   a = slot - 5'd8;
            default: a = slot;
        endcase
        return INS_SET_ADDR | {5'd0, a};
    endfunction

    function automatic t_instr data_instr(input logic [7:0] d);
        return INS_DATA | {2'd0, d};
    endfunction

    function automatic t_instr disp_instr(input logic d, input logic c, input logic b);
        return INS_DISP_CTRL | {7'd0, d, c, b};
    endfunction

    // Fixed basic commands; valid for codes below CMD_INIT
    function automatic t_instr cmd_instr(input logic [3:0] cmd);
        case (cmd)
            CMD_CLEAR:      return INS_CLEAR;
            CMD_HOME:       return INS_HOME;
            CMD_CUR_LEFT:   return INS_CUR_LEFT;
            CMD_CUR_RIGHT:  return INS_CUR_RIGHT;
            CMD_SHIFT_LEFT: return INS_SHIFT_LEFT;
            CMD_SHIFT_RGHT: return INS_SHIFT_RGHT;
            CMD_ENTRY_CR:   return INS_ENTRY_CR;
            CMD_ENTRY_CL:   return INS_ENTRY_CL;
            CMD_ENTRY_DSR:  return INS_ENTRY_DSR;
            CMD_ENTRY_DSL:  return INS_ENTRY_DSL;
            default:        return INS_CLEAR;
        endcase
    endfunction

endpackage

### hdl/lcdenc_front.sv
module lcdenc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_func,
    input  logic [1:0]          i_row,
    input  logic [3:0]          i_column,
    input  logic [15:0]         i_char_code,
    input  logic [1:0]          i_display_option,
    input  logic                i_flag_value,
    input  logic [3:0]          i_command,
    input  logic                i_q_ready,
    output logic                o_push,
    output lcdenc_pkg::t_job    o_job
);
    import lcdenc_pkg::*;

    logic [7:0] r_pos, n_pos;
    logic       r_disp, n_disp;
    logic       r_ul, n_ul;
    logic       r_blink, n_blink;
    t_job       job;
    logic       accept;
    logic [7:0] pos_half, pos_full;

    assign accept   = i_valid && i_q_ready;
    assign o_ready  = i_q_ready;
    assign pos_half = {2'd0, i_row, i_column};
    assign pos_full = {3'd0, i_row, 3'd0} + {4'd0, i_column};

    always_comb begin
        job     = '0;
        n_pos   = r_pos;
        n_disp  = r_disp;
        n_ul    = r_ul;
        n_blink = r_blink;
        case (i_func)
            FN_BEGIN_HALF: begin
                n_pos        = pos_half;
                job.instr[0] = set_addr(pos_half[5:1]);
                job.instr[1] = INS_SPACE;
                job.count    = pos_half[0] ? 3'd2 : 3'd1;
            end
            FN_HALF_CHAR: begin
                n_pos = r_pos + 8'd1;
                if (r_pos == 8'd16 || r_pos == 8'd32 || r_pos == 8'd48) begin
                    job.instr[0] = set_addr(r_pos[5:1]);
                    job.instr[1] = data_instr(i_char_code[7:0]);
                    job.count    = 3'd2;
                end else begin
                    job.instr[0] = data_instr(i_char_code[7:0]);
                    job.count    = 3'd1;
                end
            end
            FN_END_HALF: begin
                job.instr[0] = INS_SPACE;
                job.count    = r_pos[0] ? 3'd1 : 3'd0;
            end
            FN_BEGIN_FULL: begin
                // cells past 31 get no set-address, but the position still moves
                n_pos        = pos_full;
                job.instr[0] = set_addr(pos_full[4:0]);
                job.count    = (pos_full[7:5] == 3'd0) ? 3'd1 : 3'd0;
            end
            FN_FULL_CHAR: begin
                n_pos = r_pos + 8'd1;
                if (r_pos == 8'd8 || r_pos == 8'd16 || r_pos == 8'd24) begin
                    job.instr[0] = set_addr(r_pos[4:0]);
                    job.instr[1] = data_instr(i_char_code[15:8]);
                    job.instr[2] = data_instr(i_char_code[7:0]);
                    job.count    = 3'd3;
                end else begin
                    job.instr[0] = data_instr(i_char_code[15:8]);
                    job.instr[1] = data_instr(i_char_code[7:0]);
                    job.count    = 3'd2;
                end
            end
            FN_DISP_FLAG: begin
                case (i_display_option)
                    OPT_DISPLAY:   n_disp  = i_flag_value;
                    OPT_UNDERLINE: n_ul    = i_flag_value;
                    OPT_BLINK:     n_blink = i_flag_value;
                    default:       ;
                endcase
                job.instr[0] = disp_instr(n_disp, n_ul, n_blink);
                job.count    = 3'd1;
            end
            FN_COMMAND: begin
                if (i_command < CMD_INIT) begin
                    job.instr[0] = cmd_instr(i_command);
                    job.count    = 3'd1;
                end else if (i_command == CMD_INIT) begin
                    job.instr[0] = INS_FUNC_BASIC;
                    job.instr[1] = disp_instr(r_disp, r_ul, r_blink);
                    job.instr[2] = INS_CLEAR;
                    job.instr[3] = INS_ENTRY_CR;
                    job.count    = 3'd4;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 8'd0;
            r_disp  <= 1'b1;
            r_ul    <= 1'b1;
            r_blink <= 1'b1;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_disp  <= n_disp;
            r_ul    <= n_ul;
            r_blink <= n_blink;
        end
    end

    // items that send nothing never reach the queue
    assign o_push = accept && (job.count != 3'd0);
    assign o_job  = job;

endmodule

### hdl/lcdenc_queue.sv
module lcdenc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lcdenc_pkg::t_job    i_job,
    output logic                o_ready,
    input  logic                i_pop,
    output logic                o_valid,
    output lcdenc_pkg::t_job    o_job
);
    import lcdenc_pkg::*;

    t_job       r_mem [QUEUE_DEP];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'(QUEUE_DEP));
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_ready && !i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QUEUE_DEP))
        else $error("queue count out of range");

endmodule

### hdl/lcdenc_back.sv
module lcdenc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  lcdenc_pkg::t_job    i_q_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_serial_byte,
    output logic                o_last
);
    import lcdenc_pkg::*;

    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_ins;
    logic [1:0] r_byte;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    t_instr     cur;
    logic [7:0] byte_val;
    logic       load, emit, is_last;

    assign load    = !r_out_valid || i_ready;
    assign emit    = load && r_busy;
    assign cur     = r_job.instr[r_ins];
    assign is_last = ({1'b0, r_ins} == r_job.count - 3'd1) && (r_byte == PH_LOW);
    assign o_pop   = i_q_valid && (!r_busy || (emit && is_last));

    always_comb begin
        case (r_byte)
            PH_SYNC: byte_val = SYNC_BASE | {5'd0, cur[8], cur[9], 1'b0};
            PH_HIGH: byte_val = {cur[7:4], 4'd0};
            PH_LOW:  byte_val = {cur[3:0], 4'd0};
            default: byte_val = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ins  <= 2'd0;
            r_byte <= PH_SYNC;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_ins  <= 2'd0;
            r_byte <= PH_SYNC;
        end else if (emit) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else if (r_byte == PH_LOW) begin
                r_byte <= PH_SYNC;
                r_ins  <= r_ins + 2'd1;
            end else begin
                r_byte <= r_byte + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
        if (load) begin
            r_out_byte <= byte_val;
            r_out_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= emit;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_serial_byte = r_out_byte;
    assign o_last        = r_out_last;

    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_job.count != 3'd0 && r_job.count <= 3'(MAX_INS)))
        else $error("active job with bad count");

    a_ins_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_ins} < r_job.count && r_byte != 2'd3))
        else $error("sequencer index past end of job");

endmodule

### hdl/lcd_text_serial_command_encoder.sv
// Bytes pass through the job queue, the job register and the output register.
// Throughput: one serial byte per cycle while jobs wait and i_out_ready is high;
//   an item sends 3 bytes per instruction, 0 to 12 bytes in all;
//   an item that sends no bytes is accepted without entering the queue.
// A 2-deep job queue lets the input keep accepting while bytes drain.
// Reset (i_rst_n low, synchronous): position 0, all display flags 1, queue
//   and sequencer empty, no output valid.
module lcd_text_serial_command_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [1:0]  i_row,
    input  logic [3:0]  i_column,
    input  logic [15:0] i_char_code,
    input  logic [1:0]  i_display_option,
    input  logic        i_flag_value,
    input  logic [3:0]  i_command,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_serial_byte,
    output logic        o_last
);
    import lcdenc_pkg::*;

    // front -> queue
    logic q_push, q_ready;
    t_job push_job;
    // queue -> back
    logic q_valid, q_pop;
    t_job pop_job;

    // Front: decodes each transaction into up to four 10-bit instructions
    // and owns the text position and display flags. Nothing is queued for
    // items that produce no bytes.
    lcdenc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_func           (i_func),
        .i_row            (i_row),
        .i_column         (i_column),
        .i_char_code      (i_char_code),
        .i_display_option (i_display_option),
        .i_flag_value     (i_flag_value),
        .i_command        (i_command),
        .i_q_ready        (q_ready),
        .o_push           (q_push),
        .o_job            (push_job)
    );

    lcdenc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    // Back: sync / high nibble / low nibble per instruction; the next job
    // is loaded on the cycle the final byte goes out, so queued frames run gap-free.
    lcdenc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_job       (pop_job),
        .o_pop         (q_pop),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_serial_byte (o_serial_byte),
        .o_last        (o_last)
    );

endmodule
